[rtl/abae_pkg.sv]
// shared types, constants and checksum function for the alternating bit endpoint
`default_nettype none
package abae_pkg;

    localparam int PAYLOAD_BYTES_DEFAULT = 16;
    localparam int CHECKED_BYTES         = 8;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [63:0] ACK_WORD      = 64'h0000_0000_004B_4341;

    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_SEND = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic {
        PKT_MSG = 1'b0,
        PKT_ACK = 1'b1
    } pkt_type_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        pkt_type;
        logic        good;
        logic        seq_is0;
        logic        seq_is1;
        logic [15:0] sum;
        logic [63:0] data_low;
        logic [63:0] data_high;
    } cmd_t;

    typedef struct packed {
        logic        tx_valid;
        logic        tx_type;
        logic        tx_seq;
        logic [15:0] tx_checksum;
        logic [63:0] tx_data_low;
        logic [63:0] tx_data_high;
        logic        deliver_valid;
        logic [63:0] deliver_low;
        logic [63:0] deliver_high;
        logic        ack_done;
        logic        refused;
        logic [15:0] drop_total;
    } result_t;

    // 16-bit wrapping sum of the first bytes taken as signed
    function automatic logic [15:0] byte_sum(input logic [63:0] word);
        logic [15:0] acc;
        acc = '0;
        for (int i = 0; i < CHECKED_BYTES; i++) begin
            acc = acc + {{8{word[8*i+7]}}, word[8*i +: 8]};
        end
        return acc;
    endfunction

    localparam logic [15:0] ACK_CHECKSUM = ~byte_sum(ACK_WORD);

endpackage
`default_nettype wire

[rtl/abae_front.sv]
// front end: unpacks input words, checks the checksum and classifies them
`default_nettype none
module abae_front #(
    parameter int PAYLOAD_BYTES = abae_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  wire logic [151:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    output abae_pkg::cmd_t    cmd
);

    localparam int          HIGH_BITS = (PAYLOAD_BYTES - 8) * 8;
    localparam logic [63:0] HIGH_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF << HIGH_BITS);

    logic [7:0]  pkt_seq;
    logic [15:0] pkt_checksum;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [15:0] sum;

    assign pkt_seq      = s_tdata[7:0];
    assign pkt_checksum = s_tdata[23:8];
    assign data_low     = s_tdata[87:24];
    assign data_high    = s_tdata[151:88];
    assign sum          = abae_pkg::byte_sum(data_low);

    always_comb begin
        cmd.op        = s_tuser[1:0];
        cmd.pkt_type  = s_tuser[2];
        cmd.good      = (sum + pkt_checksum) == 16'hFFFF;
        cmd.seq_is0   = pkt_seq == 8'd0;
        cmd.seq_is1   = pkt_seq == 8'd1;
        cmd.sum       = sum;
        cmd.data_low  = data_low;
        cmd.data_high = data_high & HIGH_MASK;
    end

endmodule
`default_nettype wire

[rtl/abae_queue.sv]
// short queue of classified words between front and back
`default_nettype none
module abae_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire abae_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output abae_pkg::cmd_t      head
);

    localparam int PTR_W = (abae_pkg::QUEUE_DEPTH > 1) ? $clog2(abae_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(abae_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(abae_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(abae_pkg::QUEUE_DEPTH - 1);

    abae_pkg::cmd_t    store_reg [abae_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == DEPTH_CNT;
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/abae_back.sv]
// back end: protocol state, timer, retransmission and result register
`default_nettype none
module abae_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [15:0]    cfg_data,
    input  wire logic           q_not_empty,
    input  wire abae_pkg::cmd_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output abae_pkg::result_t   m_result
);

    logic [15:0]       timeout_reg;
    logic              recv_bit_reg, recv_bit_next;
    logic              send_bit_reg, send_bit_next;
    logic              pending_reg, pending_next;
    logic [63:0]       pend_low_reg;
    logic [63:0]       pend_high_reg;
    logic [15:0]       pend_sum_reg;
    logic              pend_bit_reg;
    logic              store_pending;
    logic [15:0]       tick_reg, tick_next;
    logic [15:0]       tick_inc;
    logic [15:0]       drop_reg, drop_next;
    logic              out_valid_reg;
    abae_pkg::result_t out_reg, res;
    logic              seq_match_rx;
    logic              seq_match_ack;

    assign cfg_ready = 1'b1;
    assign q_pop     = q_not_empty && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;

    assign seq_match_rx  = recv_bit_reg ? q_head.seq_is1 : q_head.seq_is0;
    assign seq_match_ack = send_bit_reg ? q_head.seq_is1 : q_head.seq_is0;
    assign tick_inc      = tick_reg + 16'd1;

    always_comb begin
        res           = '0;
        recv_bit_next = recv_bit_reg;
        send_bit_next = send_bit_reg;
        pending_next  = pending_reg;
        tick_next     = tick_reg;
        drop_next     = drop_reg;
        store_pending = 1'b0;
        case (abae_pkg::op_t'(q_head.op))
            abae_pkg::OP_RX: begin
                if (abae_pkg::pkt_type_t'(q_head.pkt_type) == abae_pkg::PKT_MSG) begin
                    res.tx_valid    = 1'b1;
                    res.tx_type     = abae_pkg::PKT_ACK;
                    res.tx_checksum = abae_pkg::ACK_CHECKSUM;
                    res.tx_data_low = abae_pkg::ACK_WORD;
                    if (q_head.good && seq_match_rx) begin
                        res.tx_seq        = recv_bit_reg;
                        res.deliver_valid = 1'b1;
                        res.deliver_low   = q_head.data_low;
                        res.deliver_high  = q_head.data_high;
                        recv_bit_next     = !recv_bit_reg;
                    end else begin
                        res.tx_seq = !recv_bit_reg;
                    end
                end else if (q_head.good && pending_reg && seq_match_ack) begin
                    send_bit_next = !send_bit_reg;
                    pending_next  = 1'b0;
                    tick_next     = '0;
                    res.ack_done  = 1'b1;
                end
            end
            abae_pkg::OP_SEND: begin
                if (pending_reg) begin
                    res.refused = 1'b1;
                end else begin
                    store_pending    = 1'b1;
                    pending_next     = 1'b1;
                    tick_next        = '0;
                    res.tx_valid     = 1'b1;
                    res.tx_type      = abae_pkg::PKT_MSG;
                    res.tx_seq       = send_bit_reg;
                    res.tx_checksum  = ~q_head.sum;
                    res.tx_data_low  = q_head.data_low;
                    res.tx_data_high = q_head.data_high;
                end
            end
            abae_pkg::OP_TICK: begin
                if (pending_reg) begin
                    if (tick_inc >= timeout_reg) begin
                        tick_next        = '0;
                        drop_next        = drop_reg + 16'd1;
                        res.tx_valid     = 1'b1;
                        res.tx_type      = abae_pkg::PKT_MSG;
                        res.tx_seq       = pend_bit_reg;
                        res.tx_checksum  = pend_sum_reg;
                        res.tx_data_low  = pend_low_reg;
                        res.tx_data_high = pend_high_reg;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
            end
            default: begin
            end
        endcase
        res.drop_total = drop_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= abae_pkg::TIMEOUT_RESET;
            recv_bit_reg  <= 1'b0;
            send_bit_reg  <= 1'b0;
            pending_reg   <= 1'b0;
            tick_reg      <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            if (q_pop) begin
                recv_bit_reg  <= recv_bit_next;
                send_bit_reg  <= send_bit_next;
                pending_reg   <= pending_next;
                tick_reg      <= tick_next;
                drop_reg      <= drop_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= res;
        end
        if (q_pop && store_pending) begin
            pend_low_reg  <= q_head.data_low;
            pend_high_reg <= q_head.data_high;
            pend_sum_reg  <= ~q_head.sum;
            pend_bit_reg  <= send_bit_reg;
        end
    end

    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !pending_reg |-> tick_reg == 16'd0)
        else $error("timer running with nothing pending");

    a_send_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.op == abae_pkg::OP_SEND) |=> pending_reg)
        else $error("send word left nothing pending");

    a_drop_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && drop_reg != $past(drop_reg)) |->
            drop_reg == $past(drop_reg) + 16'd1)
        else $error("drop count jumped");

    a_ack_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.ack_done) |-> (!out_reg.tx_valid && !out_reg.deliver_valid))
        else $error("ack completion carried a transmission or delivery");

    a_ack_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && res.ack_done) |=> (!pending_reg && send_bit_reg != $past(send_bit_reg)))
        else $error("acknowledged message still pending");

endmodule
`default_nettype wire

[rtl/alternating_bit_arq_endpoint.sv]
// top level of the alternating bit stop-and-wait endpoint
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tdata 152b, s_tuser 3b
//  m_       out        m_tvalid / m_tready  m_tdata 296b, m_tuser 5b
//  cfg_     in         cfg_valid/cfg_ready  cfg_data 16b timeout in ticks
//
// one word in and one result out per cycle while m_tready stays high; classify logic is
// combinational in front of a two-entry queue, and the result register loads when the
// queue pops a word, raising m_tvalid until m_tready takes the result
// reset is synchronous on aresetn, with no clearing pass
// a stalled m_ side fills the queue and then drops s_tready; cfg_ready is always high
`default_nettype none
module alternating_bit_arq_endpoint #(
    parameter int PAYLOAD_BYTES = abae_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pkt_seq, pkt_checksum, data_low, data_high
    input  wire logic [151:0] s_tdata,
    // op, pkt_type
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tx_seq, tx_checksum, tx_data_low, tx_data_high, deliver_low, deliver_high,
    // drop_total, zero fill
    output logic [295:0]      m_tdata,
    // tx_valid, tx_type, deliver_valid, ack_done, refused
    output logic [4:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    abae_pkg::cmd_t    front_cmd;
    abae_pkg::cmd_t    q_head;
    abae_pkg::result_t result;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;

    assign s_tready = !q_full;

    abae_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (front_cmd)
    );

    abae_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    abae_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result)
    );

    assign m_tdata = {7'd0, result.drop_total, result.deliver_high, result.deliver_low,
                      result.tx_data_high, result.tx_data_low, result.tx_checksum,
                      result.tx_seq};
    assign m_tuser = {result.refused, result.ack_done, result.deliver_valid,
                      result.tx_type, result.tx_valid};

endmodule
`default_nettype wire

[tb/tb_top.sv]
// testbench for the alternating bit endpoint: directed and random traffic checked against a predictor
`default_nettype none
module tb_top;

    localparam int PAYLOAD_BYTES = abae_pkg::PAYLOAD_BYTES_DEFAULT;
    localparam logic [63:0] HIGH_KEEP = (PAYLOAD_BYTES >= 16) ? '1 :
        ((64'd1 << (8 * (PAYLOAD_BYTES - 8))) - 64'd1);
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct {
        logic [1:0]          op;
        abae_pkg::pkt_type_t ptype;
        logic [7:0]          seq;
        logic [15:0]         chk;
        logic [63:0]         lo;
        logic [63:0]         hi;
    } arrival_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    // pkt_seq, pkt_checksum, data_low, data_high
    logic [151:0] s_tdata;
    // op, pkt_type
    logic [2:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    // tx_seq, tx_checksum, tx_data_low, tx_data_high, deliver_low, deliver_high,
    // drop_total, zero fill
    logic [295:0] m_tdata;
    // tx_valid, tx_type, deliver_valid, ack_done, refused
    logic [4:0] m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] cfg_data;

    alternating_bit_arq_endpoint #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // endpoint state as predicted
    logic [15:0] timeout_now = abae_pkg::TIMEOUT_RESET;
    logic        rx_bit = 1'b0;
    logic        tx_bit = 1'b0;
    logic        held_valid = 1'b0;
    logic [63:0] held_lo = '0;
    logic [63:0] held_hi = '0;
    logic [15:0] held_sum = '0;
    logic        held_bit = 1'b0;
    logic [15:0] tick_run = '0;
    logic [15:0] drop_run = '0;

    abae_pkg::result_t replies_due[$];
    int failures = 0;
    int items_sent = 0;
    int results_seen = 0;
    int deliveries = 0;
    int resends = 0;
    int refusals = 0;
    int acks_taken = 0;
    bit idling_on = 1'b1;

    function automatic logic [15:0] signed_byte_total(input logic [63:0] v);
        logic [15:0] acc;
        logic signed [7:0] b;
        acc = '0;
        for (int i = 0; i < abae_pkg::CHECKED_BYTES; i++) begin
            b = v[8*i +: 8];
            acc = acc + 16'(b);
        end
        return acc;
    endfunction

    function automatic logic [15:0] seal(input logic [63:0] v);
        return ~signed_byte_total(v);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic abae_pkg::result_t with_ack(input abae_pkg::result_t r,
                                                   input logic seqb);
        r.tx_valid     = 1'b1;
        r.tx_type      = abae_pkg::PKT_ACK;
        r.tx_seq       = seqb;
        r.tx_checksum  = seal(abae_pkg::ACK_WORD);
        r.tx_data_low  = abae_pkg::ACK_WORD;
        r.tx_data_high = '0;
        return r;
    endfunction

    function automatic abae_pkg::result_t with_held(input abae_pkg::result_t r);
        r.tx_valid     = 1'b1;
        r.tx_type      = abae_pkg::PKT_MSG;
        r.tx_seq       = held_bit;
        r.tx_checksum  = held_sum;
        r.tx_data_low  = held_lo;
        r.tx_data_high = held_hi;
        return r;
    endfunction

    function automatic abae_pkg::result_t endpoint_step(input arrival_t w);
        abae_pkg::result_t r;
        logic [63:0] hi;
        logic [15:0] total;
        logic good;
        r = '0;
        hi = w.hi & HIGH_KEEP;
        total = signed_byte_total(w.lo) + w.chk;
        good = (total == 16'hFFFF);
        case (w.op)
            abae_pkg::OP_RX: begin
                if (w.ptype == abae_pkg::PKT_MSG) begin
                    if (good && w.seq == {7'd0, rx_bit}) begin
                        r.deliver_valid = 1'b1;
                        r.deliver_low   = w.lo;
                        r.deliver_high  = hi;
                        r = with_ack(r, rx_bit);
                        rx_bit = ~rx_bit;
                        deliveries++;
                    end else begin
                        r = with_ack(r, ~rx_bit);
                    end
                end else if (good && held_valid && w.seq == {7'd0, tx_bit}) begin
                    tx_bit = ~tx_bit;
                    held_valid = 1'b0;
                    tick_run = '0;
                    r.ack_done = 1'b1;
                    acks_taken++;
                end
            end
            abae_pkg::OP_SEND: begin
                if (held_valid) begin
                    r.refused = 1'b1;
                    refusals++;
                end else begin
                    held_lo = w.lo;
                    held_hi = hi;
                    held_sum = seal(w.lo);
                    held_bit = tx_bit;
                    held_valid = 1'b1;
                    tick_run = '0;
                    r = with_held(r);
                end
            end
            abae_pkg::OP_TICK: begin
                if (held_valid) begin
                    tick_run = tick_run + 16'd1;
                    if (tick_run >= timeout_now) begin
                        tick_run = '0;
                        drop_run = drop_run + 16'd1;
                        r = with_held(r);
                        resends++;
                    end
                end
            end
            default: ;
        endcase
        r.drop_total = drop_run;
        return r;
    endfunction

    function automatic arrival_t make_word(input logic [1:0] op,
                                           input abae_pkg::pkt_type_t ptype,
                                           input logic [7:0] seq, input logic [15:0] chk,
                                           input logic [63:0] lo, input logic [63:0] hi);
        arrival_t w;
        w.op = op;
        w.ptype = ptype;
        w.seq = seq;
        w.chk = chk;
        w.lo = lo;
        w.hi = hi;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        failures++;
        $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic offer_word(input arrival_t w);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.hi, w.lo, w.chk, w.seq};
        s_tuser  <= {w.ptype, w.op};
        do @(posedge aclk); while (!s_tready);
        replies_due.push_back(endpoint_step(w));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_now = ticks;
    endtask

    task automatic test_idle_items();
        offer_word(make_word(abae_pkg::OP_TICK, abae_pkg::PKT_MSG, 8'd0, 16'd0, '0, '0));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_ACK, 8'd0, seal(64'd0), '0, '0));
        offer_word(make_word(OP_SPARE, abae_pkg::PKT_ACK, 8'hFF, 16'hFFFF, '1, '1));
    endtask

    task automatic test_receive_path();
        logic [63:0] lo;
        lo = rand64();
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_MSG, 8'd0, seal('1), '1, '1));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_MSG, 8'd0, seal(lo), lo,
                             rand64()));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_MSG, 8'd1, seal(lo) ^ 16'h0100,
                             lo, rand64()));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_MSG, 8'h81, seal(lo), lo,
                             rand64()));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_MSG, 8'd1, 16'hFFFF, '0, '0));
    endtask

    task automatic test_send_and_retry();
        logic [63:0] lo;
        lo = rand64();
        set_timeout(16'd2);
        offer_word(make_word(abae_pkg::OP_SEND, abae_pkg::PKT_MSG, 8'd0, 16'd0, lo,
                             rand64()));
        offer_word(make_word(abae_pkg::OP_SEND, abae_pkg::PKT_MSG, 8'd0, 16'd0, rand64(),
                             rand64()));
        offer_word(make_word(abae_pkg::OP_TICK, abae_pkg::PKT_MSG, 8'd0, 16'd0, '0, '0));
        offer_word(make_word(abae_pkg::OP_TICK, abae_pkg::PKT_MSG, 8'd0, 16'd0, '0, '0));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_ACK, 8'd0, seal(lo) ^ 16'h0001,
                             lo, '0));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_ACK, 8'd2, seal(lo), lo, '0));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_ACK, 8'd0, seal(lo), lo, '0));
        offer_word(make_word(abae_pkg::OP_TICK, abae_pkg::PKT_MSG, 8'd0, 16'd0, '0, '0));
    endtask

    task automatic test_zero_timeout();
        set_timeout(16'd0);
        offer_word(make_word(abae_pkg::OP_SEND, abae_pkg::PKT_MSG, 8'd0, 16'd0, '1, 64'd0));
        offer_word(make_word(abae_pkg::OP_TICK, abae_pkg::PKT_MSG, 8'd0, 16'd0, '0, '0));
        offer_word(make_word(abae_pkg::OP_TICK, abae_pkg::PKT_MSG, 8'd0, 16'd0, '0, '0));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_ACK, {7'd0, tx_bit}, 16'h0000,
                             '0, '0));
        offer_word(make_word(abae_pkg::OP_RX, abae_pkg::PKT_ACK, {7'd0, tx_bit}, seal('0),
                             '0, '0));
    endtask

    task automatic test_random_traffic(input logic [15:0] ticks, input int count);
        arrival_t w;
        int pick;
        logic flip;
        set_timeout(ticks);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            flip = ($urandom_range(0, 3) == 0);
            w.lo = rand64();
            w.hi = rand64();
            w.chk = seal(w.lo);
            w.ptype = abae_pkg::PKT_MSG;
            w.seq = '0;
            if (pick < 30) begin
                w.op = abae_pkg::OP_RX;
                w.seq = {7'd0, rx_bit ^ flip};
            end else if (pick < 45) begin
                w.op = abae_pkg::OP_RX;
                w.ptype = abae_pkg::PKT_ACK;
                w.seq = {7'd0, tx_bit ^ flip};
            end else if (pick < 60) begin
                w.op = abae_pkg::OP_SEND;
                w.chk = 16'($urandom);
            end else if (pick < 85) begin
                w.op = abae_pkg::OP_TICK;
            end else begin
                w.op = 2'($urandom_range(0, 3));
                w.ptype = abae_pkg::pkt_type_t'($urandom_range(0, 1));
                w.seq = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0)
                    w.chk = 16'($urandom);
            end
            offer_word(w);
        end
    endtask

    initial begin
        m_tready <= 1'b1;
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    abae_pkg::result_t got;
    abae_pkg::result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.tx_seq        = m_tdata[0];
            got.tx_checksum   = m_tdata[16:1];
            got.tx_data_low   = m_tdata[80:17];
            got.tx_data_high  = m_tdata[144:81];
            got.deliver_low   = m_tdata[208:145];
            got.deliver_high  = m_tdata[272:209];
            got.drop_total    = m_tdata[288:273];
            got.tx_valid      = m_tuser[0];
            got.tx_type       = m_tuser[1];
            got.deliver_valid = m_tuser[2];
            got.ack_done      = m_tuser[3];
            got.refused       = m_tuser[4];
            results_seen++;
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[63:0], '0);
            end else begin
                want = replies_due.pop_front();
                if (got.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", 64'(got.tx_valid), 64'(want.tx_valid));
                if (got.tx_type !== want.tx_type)
                    report_mismatch("tx_type", 64'(got.tx_type), 64'(want.tx_type));
                if (got.tx_seq !== want.tx_seq)
                    report_mismatch("tx_seq", 64'(got.tx_seq), 64'(want.tx_seq));
                if (got.tx_checksum !== want.tx_checksum)
                    report_mismatch("tx_checksum", 64'(got.tx_checksum),
                                    64'(want.tx_checksum));
                if (got.tx_data_low !== want.tx_data_low)
                    report_mismatch("tx_data_low", got.tx_data_low, want.tx_data_low);
                if (got.tx_data_high !== want.tx_data_high)
                    report_mismatch("tx_data_high", got.tx_data_high, want.tx_data_high);
                if (got.deliver_valid !== want.deliver_valid)
                    report_mismatch("deliver_valid", 64'(got.deliver_valid),
                                    64'(want.deliver_valid));
                if (got.deliver_low !== want.deliver_low)
                    report_mismatch("deliver_low", got.deliver_low, want.deliver_low);
                if (got.deliver_high !== want.deliver_high)
                    report_mismatch("deliver_high", got.deliver_high, want.deliver_high);
                if (got.ack_done !== want.ack_done)
                    report_mismatch("ack_done", 64'(got.ack_done), 64'(want.ack_done));
                if (got.refused !== want.refused)
                    report_mismatch("refused", 64'(got.refused), 64'(want.refused));
                if (got.drop_total !== want.drop_total)
                    report_mismatch("drop_total", 64'(got.drop_total),
                                    64'(want.drop_total));
            end
        end
    end

    initial begin
        int waited;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_items();
        test_receive_path();
        test_send_and_retry();
        test_zero_timeout();
        test_random_traffic(16'd1, 76);
        test_random_traffic(16'd3, 76);
        test_random_traffic(16'hFFFF, 76);
        test_random_traffic(16'($urandom_range(2, 20)), 76);
        idling_on = 1'b0;
        test_random_traffic(16'd5, 76);

        s_tvalid <= 1'b0;
        waited = 0;
        while (replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (replies_due.size() != 0)
            report_mismatch("words never returned", 64'(replies_due.size()), '0);

        $display("sent %0d words, checked %0d results across timeouts 0 to 65535",
                 items_sent, results_seen);
        $display("%0d deliveries, %0d acknowledged sends, %0d resends, %0d refusals",
                 deliveries, acks_taken, resends, refusals);
        if (failures == 0) begin
            $display("alternating_bit_arq_endpoint regression: pass");
        end else begin
            $display("alternating_bit_arq_endpoint regression: fail");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("alternating_bit_arq_endpoint regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
rtl/abae_pkg.sv
rtl/abae_front.sv
rtl/abae_queue.sv
rtl/abae_back.sv
rtl/alternating_bit_arq_endpoint.sv
tb/tb_top.sv
